// ===== rtl/lpc_pkg.sv =====
package lpc_pkg;

  // Default width of the tick counter and the loaded counts.
  localparam int unsigned COUNT_BITS_DEF = 8;

  // Widths of the fixed payload fields.
  localparam int unsigned OP_W    = 2;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned TICKS_W = 8;

  // Operation codes carried by one input beat.
  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_SET    = 2'd1,
    OP_TOGGLE = 2'd2,
    OP_BLOOP  = 2'd3
  } op_t;

  // LED modes; new_mode codes above MODE_BLOOP are rejected.
  typedef enum logic [MODE_W-1:0] {
    MODE_OFF     = 3'd0,
    MODE_ON      = 3'd1,
    MODE_BLINK   = 3'd2,
    MODE_FLASH   = 3'd3,
    MODE_ONESHOT = 3'd4,
    MODE_BLOOP   = 3'd5
  } mode_t;

  // One registered command as it enters the update logic.
  typedef struct packed {
    op_t                op;
    logic [MODE_W-1:0]  new_mode;
    logic [TICKS_W-1:0] on_ticks;
    logic [TICKS_W-1:0] off_ticks;
    logic               bloop_flag;
  } cmd_t;

  // LED level and mode after one command.
  typedef struct packed {
    logic  led_level;
    mode_t active_mode;
  } res_t;

endpackage

// ===== rtl/led_pattern_controller_top.sv =====
// LED pattern controller. Each input beat is one command (tick, set mode, toggle or
// bloop event) and yields exactly one result beat: the LED level and the mode in force
// after it. The block takes one beat per clock while the result side takes its beats; a
// command is held in the input register and then in the result register, with the whole
// state update done as a single combinational step between the two. Ready falls only
// while both registers are full and the result side is stalled. COUNT_BITS sets the width
// of the tick counter; the on and off counts are fitted to that width when loaded.
module led_pattern_controller_top #(
  parameter int unsigned COUNT_BITS = lpc_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lpc_pkg::OP_W-1:0]    in_operation,
  input  logic [lpc_pkg::MODE_W-1:0]  in_new_mode,
  input  logic [lpc_pkg::TICKS_W-1:0] in_on_ticks,
  input  logic [lpc_pkg::TICKS_W-1:0] in_off_ticks,
  input  logic                        in_bloop_flag,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_led_level,
  output logic [lpc_pkg::MODE_W-1:0]  out_active_mode
);
  import lpc_pkg::*;

  logic  a_valid_r;
  cmd_t  a_cmd_r;
  logic  out_valid_r;
  res_t  out_res_r;
  res_t  res;
  logic  b_load, a_move;

  // The result register can load when empty or when its beat is taken.
  assign b_load   = !out_valid_r || out_ready;
  assign a_move   = a_valid_r && b_load;
  assign in_ready = !a_valid_r || b_load;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_cmd_r.op         <= op_t'(in_operation);
      a_cmd_r.new_mode   <= in_new_mode;
      a_cmd_r.on_ticks   <= in_on_ticks;
      a_cmd_r.off_ticks  <= in_off_ticks;
      a_cmd_r.bloop_flag <= in_bloop_flag;
    end
  end

  // State and update logic.
  lpc_engine #(
    .COUNT_BITS(COUNT_BITS)
  ) u_engine (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (a_move),
    .cmd  (a_cmd_r),
    .res  (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_load) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_led_level   = out_res_r.led_level;
  assign out_active_mode = out_res_r.active_mode;

  // The off mode always shows a dark LED and the on mode a lit one.
  a_fixed_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_res_r.active_mode != MODE_OFF) || !out_res_r.led_level) &&
                    ((out_res_r.active_mode != MODE_ON) || out_res_r.led_level))
    else $error("LED level disagrees with off or on mode");

  // A held command is never dropped while the result side stalls.
  a_hold_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !b_load |=> a_valid_r)
    else $error("Input register lost a command");

  // A set with an unknown mode code leaves the mode unchanged.
  a_bad_mode: assert property (@(posedge clk) disable iff (!rst_n)
    a_move && a_cmd_r.op == OP_SET && a_cmd_r.new_mode > MODE_BLOOP |->
      res.active_mode == u_engine.mode_r)
    else $error("Unknown mode code changed the mode");

  // Each command moved on shows up as a valid result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    a_move |=> out_valid_r)
    else $error("Result beat missing");

endmodule

// ===== rtl/lpc_engine.sv =====
module lpc_engine #(
  parameter int unsigned COUNT_BITS = lpc_pkg::COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  lpc_pkg::cmd_t cmd,
  output lpc_pkg::res_t res
);
  import lpc_pkg::*;

  mode_t                 mode_r, mode_nxt;
  logic [COUNT_BITS-1:0] tick_r, tick_nxt;
  logic [COUNT_BITS-1:0] chg_r, chg_nxt;
  logic [COUNT_BITS-1:0] dark_r, dark_nxt;
  logic                  led_r, led_nxt;

  logic [COUNT_BITS+TICKS_W-1:0] on_wide, off_wide;
  logic [COUNT_BITS-1:0]         on_cnt, off_cnt;
  logic [COUNT_BITS-1:0]         limit, tick_inc;

  // Loaded counts are fitted to the counter width, truncated or zero-extended.
  assign on_wide  = {{COUNT_BITS{1'b0}}, cmd.on_ticks};
  assign off_wide = {{COUNT_BITS{1'b0}}, cmd.off_ticks};
  assign on_cnt   = on_wide[COUNT_BITS-1:0];
  assign off_cnt  = off_wide[COUNT_BITS-1:0];

  // Flash uses the dark count while unlit; every other pattern uses the change count.
  assign limit    = (mode_r == MODE_FLASH && !led_r) ? dark_r : chg_r;
  assign tick_inc = tick_r + 1'b1;

  // Next state for the command at the head of the input register.
  always_comb begin
    mode_nxt = mode_r;
    tick_nxt = tick_r;
    chg_nxt  = chg_r;
    dark_nxt = dark_r;
    led_nxt  = led_r;
    case (cmd.op)
      OP_TICK: begin
        case (mode_r)
          MODE_BLINK, MODE_FLASH: begin
            if (tick_r == limit) begin
              led_nxt  = ~led_r;
              tick_nxt = '0;
            end else begin
              tick_nxt = tick_inc;
            end
          end
          MODE_ONESHOT, MODE_BLOOP: begin
            // The increment cannot wrap here as the count is below the limit.
            if (tick_r < chg_r) begin
              tick_nxt = tick_inc;
              if (tick_inc >= chg_r) begin
                led_nxt = 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
      OP_SET: begin
        if (cmd.new_mode <= MODE_BLOOP) begin
          mode_nxt = mode_t'(cmd.new_mode);
          tick_nxt = '0;
          chg_nxt  = on_cnt;
          dark_nxt = off_cnt;
          led_nxt  = (cmd.new_mode == MODE_ON) || (cmd.new_mode == MODE_ONESHOT);
        end
      end
      OP_TOGGLE: begin
        if (mode_r == MODE_ON) begin
          mode_nxt = MODE_OFF;
          led_nxt  = 1'b0;
        end else if (mode_r == MODE_OFF) begin
          mode_nxt = MODE_ON;
          led_nxt  = 1'b1;
        end
      end
      OP_BLOOP: begin
        if (mode_r == MODE_BLOOP && cmd.bloop_flag) begin
          led_nxt  = 1'b1;
          tick_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  // State registers advance once per command that moves to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_OFF;
      tick_r <= '0;
      chg_r  <= '0;
      dark_r <= '0;
      led_r  <= 1'b0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      tick_r <= tick_nxt;
      chg_r  <= chg_nxt;
      dark_r <= dark_nxt;
      led_r  <= led_nxt;
    end
  end

  assign res.led_level   = led_nxt;
  assign res.active_mode = mode_nxt;

endmodule

// ===== tb/led_pattern_controller_top_tb.sv =====
module led_pattern_controller_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpc_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1580;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned MAX_REPORTS  = 10;

  // LED level and mode as seen on one result beat.
  typedef struct packed {
    logic              led;
    logic [MODE_W-1:0] mode;
  } led_view_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     in_operation = '0;
  logic [MODE_W-1:0]   in_new_mode = '0;
  logic [TICKS_W-1:0]  in_on_ticks = '0;
  logic [TICKS_W-1:0]  in_off_ticks = '0;
  logic                in_bloop_flag = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_led_level;
  logic [MODE_W-1:0]   out_active_mode;

  // Shadow copy of the controller state.
  mode_t               shadow_mode = MODE_OFF;
  logic [TICKS_W-1:0]  shadow_tick = '0;
  logic [TICKS_W-1:0]  shadow_change = '0;
  logic [TICKS_W-1:0]  shadow_dark = '0;
  logic                shadow_led = 1'b0;

  led_view_t           pending_views[$];
  int unsigned         err_cnt = 0;
  int unsigned         mismatch_cnt = 0;
  int unsigned         cycle_cnt = 0;
  int                  src_calm = 0;
  int                  snk_calm = 0;

  led_pattern_controller_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_new_mode     (in_new_mode),
    .in_on_ticks     (in_on_ticks),
    .in_off_ticks    (in_off_ticks),
    .in_bloop_flag   (in_bloop_flag),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_led_level   (out_led_level),
    .out_active_mode (out_active_mode)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long, with calm stretches of none.
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Advances the shadow pattern by one tick.
  function automatic void advance_shadow();
    logic [TICKS_W-1:0] limit;
    case (shadow_mode)
      MODE_BLINK, MODE_FLASH: begin
        limit = (shadow_mode == MODE_FLASH && !shadow_led) ? shadow_dark : shadow_change;
        if (shadow_tick == limit) begin
          shadow_led  = ~shadow_led;
          shadow_tick = '0;
        end else begin
          shadow_tick = shadow_tick + 1'b1;
        end
      end
      MODE_ONESHOT, MODE_BLOOP: begin
        if (shadow_tick < shadow_change) begin
          shadow_tick = shadow_tick + 1'b1;
          if (shadow_tick >= shadow_change) shadow_led = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  // Applies one accepted command to the shadow state and queues the view it leaves.
  function automatic void predict_view(op_t op, logic [MODE_W-1:0] nm,
                                       logic [TICKS_W-1:0] on_t, logic [TICKS_W-1:0] off_t,
                                       logic flag);
    led_view_t v;
    case (op)
      OP_TICK: advance_shadow();
      OP_SET: begin
        if (nm <= MODE_BLOOP) begin
          shadow_mode   = mode_t'(nm);
          shadow_tick   = '0;
          shadow_change = on_t;
          shadow_dark   = off_t;
          shadow_led    = (nm == MODE_ON || nm == MODE_ONESHOT);
        end
      end
      OP_TOGGLE: begin
        if (shadow_mode == MODE_ON) begin
          shadow_mode = MODE_OFF;
          shadow_led  = 1'b0;
        end else if (shadow_mode == MODE_OFF) begin
          shadow_mode = MODE_ON;
          shadow_led  = 1'b1;
        end
      end
      default: begin
        if (shadow_mode == MODE_BLOOP && flag) begin
          shadow_led  = 1'b1;
          shadow_tick = '0;
        end
      end
    endcase
    v.led  = shadow_led;
    v.mode = shadow_mode;
    pending_views.push_back(v);
  endfunction

  // Sends one command beat. Valid is left high after acceptance so that a
  // following beat with no gap keeps it up without a glitch.
  task automatic send_cmd(op_t op, logic [MODE_W-1:0] nm, logic [TICKS_W-1:0] on_t,
                          logic [TICKS_W-1:0] off_t, logic flag);
    int gap;
    gap = idle_len(src_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_new_mode   <= nm;
    in_on_ticks   <= on_t;
    in_off_ticks  <= off_t;
    in_bloop_flag <= flag;
    do @(posedge clk); while (!in_ready);
    predict_view(op, nm, on_t, off_t, flag);
  endtask

  // Fields an operation does not use carry random values.
  task automatic tick();
    send_cmd(OP_TICK, MODE_W'($urandom), TICKS_W'($urandom), TICKS_W'($urandom),
             1'($urandom));
  endtask

  task automatic set_mode(logic [MODE_W-1:0] nm, logic [TICKS_W-1:0] on_t,
                          logic [TICKS_W-1:0] off_t);
    send_cmd(OP_SET, nm, on_t, off_t, 1'($urandom));
  endtask

  task automatic toggle();
    send_cmd(OP_TOGGLE, MODE_W'($urandom), TICKS_W'($urandom), TICKS_W'($urandom),
             1'($urandom));
  endtask

  task automatic bloop(logic flag);
    send_cmd(OP_BLOOP, MODE_W'($urandom), TICKS_W'($urandom), TICKS_W'($urandom), flag);
  endtask

  // Off mode straight after reset, and toggling between off and on.
  task automatic test_after_reset();
    tick();
    toggle();
    toggle();
  endtask

  // Rejected codes, extreme counts, and a oneshot whose count is already reached.
  task automatic test_set_mode();
    set_mode(3'd6, 8'hFF, 8'hFF);
    set_mode(3'd7, 8'h00, 8'hFF);
    set_mode(MODE_ON, 8'hFF, 8'h00);
    set_mode(MODE_ONESHOT, 8'h00, 8'hFF);
    tick();
    set_mode(MODE_OFF, 8'hFF, 8'hFF);
  endtask

  // Blink period, and toggle ignored in a patterned mode.
  task automatic test_blink();
    set_mode(MODE_BLINK, 8'd1, 8'd0);
    tick();
    tick();
    toggle();
  endtask

  // Flash uses the dark count while unlit and the change count while lit.
  task automatic test_flash();
    set_mode(MODE_FLASH, 8'd0, 8'd1);
    tick();
    tick();
    tick();
  endtask

  // Oneshot goes dark once the count is reached and then holds.
  task automatic test_oneshot();
    set_mode(MODE_ONESHOT, 8'd2, 8'd0);
    tick();
    tick();
    tick();
  endtask

  // Bloop events outside bloop mode, an event with the flag low, and a real bloop.
  task automatic test_bloop();
    bloop(1'b1);
    set_mode(MODE_BLOOP, 8'd1, 8'd0);
    bloop(1'b0);
    bloop(1'b1);
    tick();
  endtask

  function automatic logic [TICKS_W-1:0] rand_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return TICKS_W'($urandom_range(0, 7));
    if (r < 90) return TICKS_W'($urandom_range(0, 31));
    if (r < 95) return 8'hFF;
    return TICKS_W'($urandom_range(0, 255));
  endfunction

  // One random beat; a quiet run is nearly all ticks so long counts get reached.
  task automatic random_item(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet && r < 97) r = 0;
    if (r < 65) begin
      tick();
    end else if (r < 77) begin
      set_mode(MODE_W'(($urandom_range(0, 9) == 0) ? $urandom_range(6, 7)
                                                    : $urandom_range(0, 5)),
               rand_count(), rand_count());
    end else if (r < 88) begin
      toggle();
    end else begin
      bloop(1'($urandom));
    end
  endtask

  // Random segments: a mode set followed by a run of mostly ticks.
  task automatic test_random_patterns();
    int unsigned sent;
    int run;
    bit quiet;
    logic [TICKS_W-1:0] on_t;
    logic [TICKS_W-1:0] off_t;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 29) == 0);
      if (quiet) begin
        on_t  = ($urandom_range(0, 2) == 0) ? 8'hFF : TICKS_W'($urandom_range(200, 255));
        off_t = ($urandom_range(0, 2) == 0) ? 8'hFF : TICKS_W'($urandom_range(200, 255));
        run   = $urandom_range(300, 600);
      end else begin
        on_t  = rand_count();
        off_t = rand_count();
        run   = $urandom_range(4, 40);
      end
      set_mode(MODE_W'(($urandom_range(0, 11) == 0) ? $urandom_range(6, 7)
                                                     : $urandom_range(0, 5)),
               on_t, off_t);
      sent++;
      repeat (run) begin
        random_item(quiet);
        sent++;
      end
    end
  endtask

  // Result side stalls at random.
  initial begin
    int stall;
    @(posedge clk);
    forever begin
      stall = idle_len(snk_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Each result beat is compared with the oldest predicted view.
  always @(posedge clk) begin
    led_view_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_views.size() == 0) begin
        err_cnt++;
        if (mismatch_cnt < MAX_REPORTS)
          $display("unexpected result beat: led %0b mode %0d", out_led_level, out_active_mode);
        mismatch_cnt++;
      end else begin
        want = pending_views.pop_front();
        if (out_led_level !== want.led || out_active_mode !== want.mode) begin
          err_cnt++;
          if (mismatch_cnt < MAX_REPORTS)
            $display("mismatch: expected led %0b mode %0d, got led %0b mode %0d",
                     want.led, want.mode, out_led_level, out_active_mode);
          mismatch_cnt++;
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("led_pattern_controller_top_tb: errors");
      $finish;
    end
  end

  // Reset, then the tests in turn, then drain.
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_after_reset();
    test_set_mode();
    test_blink();
    test_flash();
    test_oneshot();
    test_bloop();
    test_random_patterns();
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_views.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("led_pattern_controller_top_tb: clean");
    end else begin
      $display("led_pattern_controller_top_tb: errors");
    end
    $finish;
  end

endmodule

// ===== led_pattern_controller_top.f =====
rtl/lpc_pkg.sv
rtl/lpc_engine.sv
rtl/led_pattern_controller_top.sv
tb/led_pattern_controller_top_tb.sv
